// File: hdl/yrc_pkg.sv
// shared widths, register codes, coefficients and clamp helper for the yuv to rgb converter
package yrc_pkg;

   // field and port widths
   localparam int PIX_W      = 8;
   localparam int CFG_W      = 13;
   localparam int CFG_XW     = CFG_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int ADDR_W     = 24;
   localparam int SUM_W      = 18;
   localparam int LUMA_SHIFT = 8;
   localparam int UV_W       = 2 * PIX_W;

   // default size limits
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   // register reset values
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   // conversion coefficients, luma weight is the shift by LUMA_SHIFT
   localparam logic signed [SUM_W-1:0] COEF_RV = 18'sd358;
   localparam logic signed [SUM_W-1:0] COEF_GU = 18'sd88;
   localparam logic signed [SUM_W-1:0] COEF_GV = 18'sd182;
   localparam logic signed [SUM_W-1:0] COEF_BU = 18'sd453;
   localparam logic signed [PIX_W:0]   CHROMA_OFFSET = 9'sd128;

   // floor divide by 256 and clamp to 0..255
   function automatic logic [PIX_W-1:0] shift_clamp(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-LUMA_SHIFT-1:0] q;
      logic [PIX_W-1:0] res;
      q = sum[SUM_W-1:LUMA_SHIFT];
      if (q < 0) begin
         res = '0;
      end else if (q > 10'sd255) begin
         res = '1;
      end else begin
         res = q[PIX_W-1:0];
      end
      return res;
   endfunction

   // 256*y plus a signed chroma term
   function automatic logic signed [SUM_W-1:0] luma_sum(input logic [PIX_W-1:0] y,
                                                       input logic signed [SUM_W-1:0] term);
      logic signed [SUM_W-1:0] base;
      base = $signed({2'b00, y, 8'b0});
      return base + term;
   endfunction

endpackage

// File: hdl/yrc_if.sv
// item channels: luma pair with chroma in, rgb pair with address out
interface yrc_req_if import yrc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] luma_left;
   logic [PIX_W-1:0] luma_right;
   logic [PIX_W-1:0] chroma_u;
   logic [PIX_W-1:0] chroma_v;

   modport source (output valid, luma_left, luma_right, chroma_u, chroma_v, input ready);
   modport sink   (input valid, luma_left, luma_right, chroma_u, chroma_v, output ready);
endinterface

interface yrc_rsp_if import yrc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  red_left;
   logic [PIX_W-1:0]  green_left;
   logic [PIX_W-1:0]  blue_left;
   logic [PIX_W-1:0]  red_right;
   logic [PIX_W-1:0]  green_right;
   logic [PIX_W-1:0]  blue_right;
   logic [ADDR_W-1:0] pixel_address;
   logic              frame_done;

   modport source (output valid, red_left, green_left, blue_left, red_right, green_right,
                   blue_right, pixel_address, frame_done, input ready);
   modport sink   (input valid, red_left, green_left, blue_left, red_right, green_right,
                   blue_right, pixel_address, frame_done, output ready);
endinterface

// File: hdl/yrc_line_store.sv
// chroma line store: one entry per column pair, synchronous read with registered data
module yrc_line_store #(
   parameter int DEPTH  = 2048,
   parameter int IDX_W  = 11,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/yuv420_to_rgb24_converter.sv
// top level: 4:2:0 luma pair stream to rgb888 pairs with flipped pixel address
//
// Input channel req_bus carries one horizontal luma pair per item in raster
// order, with the pair's u/v chroma; chroma is taken on even rows and stored
// in a line store, odd rows reuse the stored chroma of the same column pair.
// Output channel rsp_bus carries both converted pixels, the bottom-up address
// of the left pixel and a mark on the last pair of the frame.
// Both channels move an item at a clock edge with valid and ready high.
// Throughput is one item per cycle while rsp_bus.ready stays high; three register
// stages (line store read, chroma products, sums and clamping) lie between
// the accepting edge and rsp_bus.valid; that edge already loads the first stage.
// The csr port writes frame_width (index 0) and frame_height (index 1); write
// them only while no item is in flight. Sizes are limited to MAX_WIDTH and
// MAX_HEIGHT.
// Synchronous reset clears the column and row counters, empties the pipeline
// and loads 640 x 480. The line store is not cleared: the first row of a
// frame must be an even row, which fills it.
// When the receiver stalls, the output register holds its item and the two
// stages behind it keep filling, so up to two more items are accepted before
// req_bus.ready drops.
module yuv420_to_rgb24_converter import yrc_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data,
   yrc_req_if.sink              req_bus,
   yrc_rsp_if.source            rsp_bus
);

   localparam int PAIRS_MAX = MAX_WIDTH / 2;
   localparam int CW = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
   localparam int PW = CW + 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = RW + 1;

   // effective pair count: min with limit, halved, at least one
   function automatic logic [PW-1:0] eff_pairs(input logic [CFG_W-1:0] fw);
      logic [CFG_XW-1:0] lim;
      logic [CFG_XW-1:0] w;
      lim = CFG_XW'(MAX_WIDTH);
      w = ({1'b0, fw} > lim) ? lim : {1'b0, fw};
      w = w >> 1;
      if (w == '0) begin
         w = CFG_XW'(1);
      end
      return PW'(w);
   endfunction

   // effective height: min with limit, at least one
   function automatic logic [HW-1:0] eff_height(input logic [CFG_W-1:0] fh);
      logic [CFG_XW-1:0] lim;
      logic [CFG_XW-1:0] h;
      lim = CFG_XW'(MAX_HEIGHT);
      h = ({1'b0, fh} > lim) ? lim : {1'b0, fh};
      if (h == '0) begin
         h = CFG_XW'(1);
      end
      return HW'(h);
   endfunction

   logic [PW-1:0] pairs_ff;
   logic [HW-1:0] height_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic req_fire, row_end, frame_end;
   logic out_adv, p2_adv, p1_adv;
   logic store_wr_en, store_rd_en;
   logic [UV_W-1:0] store_rd_data;

   // stage 1 registers
   logic              p1_valid_ff;
   logic [PIX_W-1:0]  p1_luma_l_ff, p1_luma_r_ff;
   logic [UV_W-1:0]   p1_uv_ff;
   logic              p1_odd_ff;
   logic [CW-1:0]     p1_col_ff;
   logic [ADDR_W-1:0] p1_rowterm_ff;
   logic              p1_done_ff;

   // stage 2 registers
   logic                    p2_valid_ff;
   logic [PIX_W-1:0]        p2_luma_l_ff, p2_luma_r_ff;
   logic signed [SUM_W-1:0] p2_cr_ff, p2_cg_ff, p2_cb_ff;
   logic [ADDR_W-1:0]       p2_base_ff;
   logic [CW-1:0]           p2_col_ff;
   logic                    p2_done_ff;

   // output registers
   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_rl_ff, rsp_gl_ff, rsp_bl_ff, rsp_rr_ff, rsp_gr_ff, rsp_br_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_done_ff;

   // stage 1 combinational
   logic [UV_W-1:0]         chroma;
   logic signed [PIX_W:0]   u_s, v_s;
   logic signed [SUM_W-1:0] cr_in, cg_in, cb_in;
   logic [ADDR_W-1:0]       base_in;

   // stage 2 combinational
   logic [ADDR_W-1:0] addr_in;

   // configuration registers, kept in effective form
   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff  <= eff_pairs(WIDTH_RESET);
         height_ff <= eff_height(HEIGHT_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  pairs_ff  <= eff_pairs(csr_wr_data);
            REG_FRAME_HEIGHT: height_ff <= eff_height(csr_wr_data);
            default: ;
         endcase
      end
   end

   // pipeline advance, each stage moves when the next one frees up
   assign out_adv       = !rsp_valid_ff || rsp_bus.ready;
   assign p2_adv        = !p2_valid_ff || out_adv;
   assign p1_adv        = !p1_valid_ff || p2_adv;
   assign req_bus.ready = p1_adv;
   assign req_fire      = req_bus.valid && p1_adv;

   // column and row position
   assign row_end   = ({1'b0, col_ff} + PW'(1)) >= pairs_ff;
   assign frame_end = row_end && (({1'b0, row_ff} + HW'(1)) >= height_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (!row_end) begin
            col_in = col_ff + CW'(1);
         end else begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: even rows write chroma, odd rows read it back
   assign store_wr_en = req_fire && !row_ff[0];
   assign store_rd_en = req_fire && row_ff[0];

   yrc_line_store #(
      .DEPTH  (PAIRS_MAX),
      .IDX_W  (CW),
      .DATA_W (UV_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .rd_en   (store_rd_en),
      .addr    (col_ff),
      .wr_data ({req_bus.chroma_u, req_bus.chroma_v}),
      .rd_data (store_rd_data)
   );

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_adv) begin
         p1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p1_luma_l_ff  <= req_bus.luma_left;
         p1_luma_r_ff  <= req_bus.luma_right;
         p1_uv_ff      <= {req_bus.chroma_u, req_bus.chroma_v};
         p1_odd_ff     <= row_ff[0];
         p1_col_ff     <= col_ff;
         p1_rowterm_ff <= ADDR_W'(height_ff) - ADDR_W'(row_ff) - ADDR_W'(1);
         p1_done_ff    <= frame_end;
      end
   end

   // chroma products and row base address
   always_comb begin
      chroma  = p1_odd_ff ? store_rd_data : p1_uv_ff;
      u_s     = $signed({1'b0, chroma[UV_W-1:PIX_W]}) - CHROMA_OFFSET;
      v_s     = $signed({1'b0, chroma[PIX_W-1:0]}) - CHROMA_OFFSET;
      cr_in   = SUM_W'(v_s) * COEF_RV;
      cg_in   = SUM_W'(u_s) * COEF_GU + SUM_W'(v_s) * COEF_GV;
      cb_in   = SUM_W'(u_s) * COEF_BU;
      base_in = ADDR_W'(p1_rowterm_ff * ADDR_W'({pairs_ff, 1'b0}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_adv && p1_valid_ff) begin
         p2_luma_l_ff <= p1_luma_l_ff;
         p2_luma_r_ff <= p1_luma_r_ff;
         p2_cr_ff     <= cr_in;
         p2_cg_ff     <= cg_in;
         p2_cb_ff     <= cb_in;
         p2_base_ff   <= base_in;
         p2_col_ff    <= p1_col_ff;
         p2_done_ff   <= p1_done_ff;
      end
   end

   // sums, floor shift, clamp and final address
   assign addr_in = p2_base_ff + ADDR_W'({p2_col_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && p2_valid_ff) begin
         rsp_rl_ff   <= shift_clamp(luma_sum(p2_luma_l_ff, p2_cr_ff));
         rsp_gl_ff   <= shift_clamp(luma_sum(p2_luma_l_ff, -p2_cg_ff));
         rsp_bl_ff   <= shift_clamp(luma_sum(p2_luma_l_ff, p2_cb_ff));
         rsp_rr_ff   <= shift_clamp(luma_sum(p2_luma_r_ff, p2_cr_ff));
         rsp_gr_ff   <= shift_clamp(luma_sum(p2_luma_r_ff, -p2_cg_ff));
         rsp_br_ff   <= shift_clamp(luma_sum(p2_luma_r_ff, p2_cb_ff));
         rsp_addr_ff <= addr_in;
         rsp_done_ff <= p2_done_ff;
      end
   end

   // output channel
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.red_left      = rsp_rl_ff;
   assign rsp_bus.green_left    = rsp_gl_ff;
   assign rsp_bus.blue_left     = rsp_bl_ff;
   assign rsp_bus.red_right     = rsp_rr_ff;
   assign rsp_bus.green_right   = rsp_gr_ff;
   assign rsp_bus.blue_right    = rsp_br_ff;
   assign rsp_bus.pixel_address = rsp_addr_ff;
   assign rsp_bus.frame_done    = rsp_done_ff;

`ifndef SYNTHESIS
   // last pair of the frame returns both counters to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && frame_end |=> row_ff == '0 && col_ff == '0)
      else $error("counters did not wrap at frame end");

   // end of a row moves to the next row at column zero
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && row_end && !frame_end |=>
         col_ff == '0 && row_ff == RW'($past(row_ff) + 1'b1))
      else $error("row advance wrong at row end");

   // with every stage full and the receiver stalled, nothing is taken in
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && p2_valid_ff && rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("item accepted into a full pipeline");

   // an odd-row item lands in stage 1 together with its line store read
   a_odd_read: assert property (@(posedge clock) disable iff (reset)
      req_fire && row_ff[0] |=> p1_valid_ff && p1_odd_ff)
      else $error("odd-row item lost its line store read");
`endif

endmodule
